// ----- hw/rtl/interval_history_timer_unit_defines.svh -----
// Assertion macros for the interval history timer unit.
// Uses the clk and rst_n signals of the including module; no other dependencies.
`ifndef INTERVAL_HISTORY_TIMER_UNIT_DEFINES_SVH
`define INTERVAL_HISTORY_TIMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IHTU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interval history timer assertion failed");

// Next-cycle implication, checked outside reset.
`define IHTU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interval history timer assertion failed");

`endif

// ----- hw/rtl/ihtu_pkg.sv -----
// Package for the interval history timer unit: sizes, kind codes and beat types.
// No dependencies; used by every module of the block.
`default_nettype none

package ihtu_pkg;

    localparam int DEPTH = 64;
    localparam int POS_W = $clog2(DEPTH);
    localparam int CNT_W = 7;
    localparam int TICK_W = 64;

    localparam logic [1:0] KIND_MARK  = 2'd0;
    localparam logic [1:0] KIND_CHECK = 2'd1;
    localparam logic [1:0] KIND_SKIP  = 2'd2;
    localparam logic [1:0] KIND_RESET = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TICK_W-1:0] now;
    } cmd_t;

    typedef struct packed {
        logic [TICK_W-1:0] elapsed_ticks;
        logic [TICK_W-1:0] total_ticks;
        logic [TICK_W-1:0] average_ticks;
        logic [CNT_W-1:0]  mark_count;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  waddr;
        logic [TICK_W-1:0] wdata;
        logic              re;
        logic [POS_W-1:0]  raddr;
    } store_req_t;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ihtu_store.sv -----
// Mark store of the interval history timer: one write port and one registered read port.
// Depends on ihtu_pkg.
`default_nettype none

module ihtu_store (
    input  wire logic                        clk,
    input  wire ihtu_pkg::store_req_t        req,
    output logic [ihtu_pkg::TICK_W-1:0]      rd_data
);

    logic [ihtu_pkg::TICK_W-1:0] mem [ihtu_pkg::DEPTH];
    logic [ihtu_pkg::TICK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ihtu_div.sv -----
// Radix-2 restoring divider of a 64-bit dividend by a narrow divisor, one bit per cycle.
// Depends on ihtu_pkg.
`default_nettype none

module ihtu_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ihtu_pkg::div_req_t   req,
    output ihtu_pkg::div_rsp_t        rsp
);

    localparam int STEP_W = $clog2(ihtu_pkg::TICK_W + 1);

    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        done_reg, done_next;
    logic [ihtu_pkg::TICK_W-1:0] dvd_reg, dvd_next;
    logic [ihtu_pkg::CNT_W-1:0]  dsr_reg, dsr_next;
    logic [ihtu_pkg::CNT_W-1:0]  rem_reg, rem_next;
    logic [ihtu_pkg::CNT_W:0]    rem_shift;
    logic                        fits;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[ihtu_pkg::TICK_W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        step_next = step_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            step_next = STEP_W'(ihtu_pkg::TICK_W);
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - STEP_W'(1);
            dvd_next  = {dvd_reg[ihtu_pkg::TICK_W-2:0], fits};
            rem_next  = fits ? ihtu_pkg::CNT_W'(rem_shift - {1'b0, dsr_reg})
                             : rem_shift[ihtu_pkg::CNT_W-1:0];
            done_next = step_reg == STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/interval_history_timer_unit.sv -----
// Top level of the interval history timer unit: sequencer, shared adder and state.
// Depends on ihtu_pkg, ihtu_store, ihtu_div and interval_history_timer_unit_defines.svh.
//
// Usage. A command beat (kind and now) is taken at a rising edge where start is high
// and busy is low. Busy stays high while the command is worked on. The result beat
// appears on result for exactly one cycle with done high; the receiver cannot stall,
// so it must take the beat in that cycle. A new command may be started in the cycle
// where done is high.
// Steps from acceptance to done: S_ELAP, S_UPD and S_RDO, then S_OUT with an empty
// history; with marks stored, S_RDN, S_TOT1, S_TOT2 and S_DIFF follow, and with two
// or more marks S_DIV waits for the divider's average before S_OUT. One 64-bit
// adder is shared by all tick arithmetic in sequence, and the mark store has a single
// read port, so the two stored marks are read in turn.
// The unit works on one command at a time.
// Configuration: cfg_we with cfg_data writes the window length while idle; this
// clears the history.
// Reset: rst_n clears the history, the last mark and sets the window length to 64.
`default_nettype none

`include "interval_history_timer_unit_defines.svh"

module interval_history_timer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire ihtu_pkg::cmd_t                cmd,
    output logic                               done,
    output ihtu_pkg::result_t                  result,
    input  wire logic                          cfg_we,
    input  wire logic [ihtu_pkg::CNT_W-1:0]    cfg_data
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_ELAP = 4'd1;
    localparam logic [ST_W-1:0] S_UPD  = 4'd2;
    localparam logic [ST_W-1:0] S_RDO  = 4'd3;
    localparam logic [ST_W-1:0] S_RDN  = 4'd4;
    localparam logic [ST_W-1:0] S_TOT1 = 4'd5;
    localparam logic [ST_W-1:0] S_TOT2 = 4'd6;
    localparam logic [ST_W-1:0] S_DIFF = 4'd7;
    localparam logic [ST_W-1:0] S_DIV  = 4'd8;
    localparam logic [ST_W-1:0] S_OUT  = 4'd9;

    localparam int TW = ihtu_pkg::TICK_W;
    localparam int CW = ihtu_pkg::CNT_W;
    localparam int PW = ihtu_pkg::POS_W;

    logic [ST_W-1:0]        state_reg, state_next;
    ihtu_pkg::cmd_t         cmd_reg, cmd_next;
    logic [TW-1:0]          elapsed_reg, elapsed_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [TW-1:0]          avg_reg, avg_next;
    logic [TW-1:0]          tmp_reg, tmp_next;
    logic [TW-1:0]          old_raw_reg, old_raw_next;
    logic [TW-1:0]          new_raw_reg, new_raw_next;
    logic [PW-1:0]          newest_reg, newest_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [TW-1:0]          last_mark_reg, last_mark_next;
    logic [TW-1:0]          offset_reg, offset_next;
    logic [CW-1:0]          win_reg, win_next;
    logic                   done_reg, done_next;
    ihtu_pkg::result_t      result_reg, result_next;

    logic [TW-1:0]          alu_a, alu_b, alu_y;
    logic                   alu_sub;
    logic [CW-1:0]          newest_inc;
    logic [PW-1:0]          newest_adv;
    logic [CW:0]            oldest_sum;
    logic [CW:0]            oldest_wrap;
    logic [PW-1:0]          oldest_pos;
    logic [CW-1:0]          cfg_win;

    ihtu_pkg::store_req_t   store_req;
    logic [TW-1:0]          store_rd;
    ihtu_pkg::div_req_t     div_req;
    ihtu_pkg::div_rsp_t     div_rsp;

    ihtu_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (store_rd)
    );

    ihtu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign alu_y = alu_a + (alu_b ^ {TW{alu_sub}}) + TW'(alu_sub);

    always_comb
    begin
        newest_inc  = CW'(newest_reg) + CW'(1);
        newest_adv  = (count_reg == '0) ? newest_reg
                    : (newest_inc == win_reg) ? '0 : newest_inc[PW-1:0];
        oldest_sum  = (CW+1)'(newest_reg) + (CW+1)'(win_reg) + (CW+1)'(1)
                    - (CW+1)'(count_reg);
        oldest_wrap = (oldest_sum >= (CW+1)'(win_reg))
                    ? oldest_sum - (CW+1)'(win_reg) : oldest_sum;
        oldest_pos  = oldest_wrap[PW-1:0];
        cfg_win     = (cfg_data == '0) ? CW'(1)
                    : (cfg_data > CW'(ihtu_pkg::DEPTH)) ? CW'(ihtu_pkg::DEPTH) : cfg_data;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        elapsed_next   = elapsed_reg;
        total_next     = total_reg;
        avg_next       = avg_reg;
        tmp_next       = tmp_reg;
        old_raw_next   = old_raw_reg;
        new_raw_next   = new_raw_reg;
        newest_next    = newest_reg;
        count_next     = count_reg;
        last_mark_next = last_mark_reg;
        offset_next    = offset_reg;
        win_next       = win_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        alu_a          = cmd_reg.now;
        alu_b          = last_mark_reg;
        alu_sub        = 1'b1;
        store_req      = '0;
        div_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    win_next    = cfg_win;
                    count_next  = '0;
                    newest_next = '0;
                end
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_ELAP;
                end
            end
            S_ELAP:
            begin
                elapsed_next = (cmd_reg.kind == ihtu_pkg::KIND_RESET) ? '0 : alu_y;
                state_next   = S_UPD;
            end
            S_UPD:
            begin
                alu_a = cmd_reg.now;
                alu_b = offset_reg;
                case (cmd_reg.kind)
                    ihtu_pkg::KIND_MARK:
                    begin
                        last_mark_next  = cmd_reg.now;
                        newest_next     = newest_adv;
                        count_next      = (count_reg < win_reg) ? count_reg + CW'(1)
                                                                : count_reg;
                        store_req.we    = 1'b1;
                        store_req.waddr = newest_adv;
                        store_req.wdata = alu_y;
                    end
                    ihtu_pkg::KIND_SKIP:
                    begin
                        alu_a          = offset_reg;
                        alu_b          = elapsed_reg;
                        alu_sub        = 1'b0;
                        last_mark_next = cmd_reg.now;
                        offset_next    = alu_y;
                    end
                    ihtu_pkg::KIND_RESET:
                    begin
                        last_mark_next  = cmd_reg.now;
                        newest_next     = '0;
                        count_next      = CW'(1);
                        store_req.we    = 1'b1;
                        store_req.waddr = '0;
                        store_req.wdata = alu_y;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_RDO;
            end
            S_RDO:
            begin
                total_next = '0;
                avg_next   = '0;
                if (count_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    store_req.re    = 1'b1;
                    store_req.raddr = oldest_pos;
                    state_next      = S_RDN;
                end
            end
            S_RDN:
            begin
                old_raw_next    = store_rd;
                store_req.re    = 1'b1;
                store_req.raddr = newest_reg;
                state_next      = S_TOT1;
            end
            S_TOT1:
            begin
                new_raw_next = store_rd;
                alu_a        = old_raw_reg;
                alu_b        = offset_reg;
                alu_sub      = 1'b0;
                tmp_next     = alu_y;
                state_next   = S_TOT2;
            end
            S_TOT2:
            begin
                alu_a      = cmd_reg.now;
                alu_b      = tmp_reg;
                total_next = alu_y;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                alu_a = new_raw_reg;
                alu_b = old_raw_reg;
                if (count_reg >= CW'(2))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = alu_y;
                    div_req.divisor  = count_reg - CW'(1);
                    state_next       = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                result_next.elapsed_ticks = elapsed_reg;
                result_next.total_ticks   = total_reg;
                result_next.average_ticks = avg_reg;
                result_next.mark_count    = count_reg;
                done_next                 = 1'b1;
                state_next                = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            newest_reg    <= '0;
            count_reg     <= '0;
            last_mark_reg <= '0;
            offset_reg    <= '0;
            win_reg       <= CW'(ihtu_pkg::DEPTH);
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            last_mark_reg <= last_mark_next;
            offset_reg    <= offset_next;
            win_reg       <= win_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        elapsed_reg <= elapsed_next;
        total_reg   <= total_next;
        avg_reg     <= avg_next;
        tmp_reg     <= tmp_next;
        old_raw_reg <= old_raw_next;
        new_raw_reg <= new_raw_next;
        result_reg  <= result_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    `IHTU_ASSERT_IMP(a_done_when_idle, done_reg, state_reg == S_IDLE)
    `IHTU_ASSERT_NXT(a_start_sets_busy, start && !busy, busy)
    `IHTU_ASSERT_IMP(a_count_in_window, 1'b1, count_reg <= win_reg)
    `IHTU_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, state_reg == S_DIV)

endmodule

`default_nettype wire

// ----- verif/tb_interval_history_timer_unit.sv -----
// Testbench for interval_history_timer_unit: a queue-fed command driver, a result monitor
// and a per-command predictor of the mark history, average and counts.
// Depends on ihtu_pkg and the interval_history_timer_unit RTL.
module tb_interval_history_timer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 100;
    localparam int TW = ihtu_pkg::TICK_W;
    localparam int CW = ihtu_pkg::CNT_W;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    ihtu_pkg::cmd_t     cmd = '0;
    logic               done;
    ihtu_pkg::result_t  result;
    logic               cfg_we = 1'b0;
    logic [CW-1:0]      cfg_data = '0;

    ihtu_pkg::cmd_t     pending_cmds [$];
    ihtu_pkg::result_t  expected_results [$];
    logic               cmd_taken = 1'b0;
    int unsigned        idle_left = 0;
    int unsigned        burst_left = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        fail_count = 0;
    logic [TW-1:0]      tick_base = '0;

    logic [TW-1:0]      hist_mark [ihtu_pkg::DEPTH];
    int unsigned        hist_newest = 0;
    int unsigned        hist_count = 0;
    int unsigned        hist_window = ihtu_pkg::DEPTH;
    logic [TW-1:0]      hist_last = '0;

    interval_history_timer_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned step_back(int unsigned pos, int unsigned n);
        return (pos + hist_window - n) % hist_window;
    endfunction

    function automatic void add_mark();
        if (hist_count != 0)
        begin
            hist_newest = (hist_newest + 1) % hist_window;
        end
        hist_mark[hist_newest] = hist_last;
        if (hist_count < hist_window)
        begin
            hist_count++;
        end
    endfunction

    function automatic void set_window(logic [CW-1:0] value);
        int unsigned v;
        v = value;
        if (v == 0)
        begin
            v = 1;
        end
        if (v > ihtu_pkg::DEPTH)
        begin
            v = ihtu_pkg::DEPTH;
        end
        hist_window = v;
        hist_count = 0;
        hist_newest = 0;
    endfunction

    function automatic ihtu_pkg::result_t predict_timer(ihtu_pkg::cmd_t c);
        ihtu_pkg::result_t r;
        logic [TW-1:0] elapsed;
        logic [TW-1:0] oldest;
        logic [TW-1:0] newest;
        int unsigned pos;
        r = '0;
        elapsed = c.now - hist_last;
        case (c.kind)
            ihtu_pkg::KIND_MARK:
            begin
                hist_last = c.now;
                add_mark();
            end
            ihtu_pkg::KIND_SKIP:
            begin
                hist_last = c.now;
                pos = hist_newest;
                for (int i = 0; i < hist_count; i++)
                begin
                    hist_mark[pos] = hist_mark[pos] + elapsed;
                    pos = step_back(pos, 1);
                end
            end
            ihtu_pkg::KIND_RESET:
            begin
                elapsed = '0;
                hist_last = c.now;
                hist_count = 0;
                hist_newest = 0;
                add_mark();
            end
            default:
            begin
            end
        endcase
        if (hist_count >= 1)
        begin
            oldest = hist_mark[step_back(hist_newest, hist_count - 1)];
            r.total_ticks = c.now - oldest;
            if (hist_count >= 2)
            begin
                newest = hist_mark[hist_newest];
                r.average_ticks = (newest - oldest) / TW'(hist_count - 1);
            end
        end
        r.elapsed_ticks = elapsed;
        r.mark_count = CW'(hist_count);
        return r;
    endfunction

    function automatic void report_field(string name, logic [TW-1:0] want,
                                         logic [TW-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            burst_left = $urandom_range(5, 20);
            return 0;
        end
        else if (r < 35)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 8);
        end
        else if (r < 95)
        begin
            return $urandom_range(9, 80);
        end
        return $urandom_range(81, 200);
    endfunction

    function automatic logic [TW-1:0] next_now();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 78)
        begin
            tick_base = tick_base + TW'($urandom_range(0, 3000));
        end
        else if (r < 86)
        begin
            tick_base = {$urandom, $urandom};
        end
        else if (r < 93)
        begin
            tick_base = '1 - TW'($urandom_range(0, 2000));
        end
        else
        begin
            tick_base = tick_base + {$urandom, $urandom};
        end
        return tick_base;
    endfunction

    // Command driver: one beat per pending entry, with random idle gaps after each accept.
    always @(negedge clk)
    begin
        logic go;
        go = start;
        if (rst_n)
        begin
            if (go && cmd_taken)
            begin
                go = 1'b0;
                idle_left = pick_gap();
            end
            if (!go)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd <= pending_cmds.pop_front();
                    go = 1'b1;
                end
            end
        end
        start <= go;
    end

    // Monitor: checks result beats, then tracks configuration writes and accepted commands.
    always @(posedge clk)
    begin
        ihtu_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual %p", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("elapsed_ticks", want.elapsed_ticks, result.elapsed_ticks);
                    report_field("total_ticks", want.total_ticks, result.total_ticks);
                    report_field("average_ticks", want.average_ticks, result.average_ticks);
                    report_field("mark_count", TW'(want.mark_count),
                                 TW'(result.mark_count));
                end
            end
            if (cfg_we)
            begin
                set_window(cfg_data);
            end
            if (start && !busy)
            begin
                expected_results.push_back(predict_timer(cmd));
            end
            cmd_taken <= start && !busy;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_cmd(logic [1:0] k, logic [TW-1:0] t);
        ihtu_pkg::cmd_t c;
        c.kind = k;
        c.now = t;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
    endtask

    task automatic gen_phase(int unsigned n, int unsigned reset_pct);
        int unsigned r;
        logic [1:0] k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < reset_pct)
            begin
                k = ihtu_pkg::KIND_RESET;
            end
            else if (r < reset_pct + 12)
            begin
                k = ihtu_pkg::KIND_SKIP;
            end
            else if (r < reset_pct + 27)
            begin
                k = ihtu_pkg::KIND_CHECK;
            end
            else
            begin
                k = ihtu_pkg::KIND_MARK;
            end
            queue_cmd(k, next_now());
        end
    endtask

    initial
    begin
        int unsigned phase_window [8];
        int unsigned phase_items [8];
        int unsigned phase_reset [8];
        logic [CW-1:0] w;
        phase_window = '{0, 1, 2, 3, 7, 64, 127, 0};
        phase_items = '{30, 30, 40, 40, 40, 110, 80, 40};
        phase_reset = '{4, 4, 4, 4, 3, 0, 1, 3};
        for (int i = 0; i < ihtu_pkg::DEPTH; i++)
        begin
            hist_mark[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty history, then wrap-around of the tick count and reseeding.
        queue_cmd(ihtu_pkg::KIND_CHECK, 64'd0);
        queue_cmd(ihtu_pkg::KIND_SKIP, 64'd5);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'd10);
        queue_cmd(ihtu_pkg::KIND_CHECK, 64'd15);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'd30);
        queue_cmd(ihtu_pkg::KIND_SKIP, 64'd50);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'd77);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'hFFFF_FFFF_FFFF_FFF0);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'd5);
        queue_cmd(ihtu_pkg::KIND_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_cmd(ihtu_pkg::KIND_SKIP, 64'h0000_0000_0000_0003);
        queue_cmd(ihtu_pkg::KIND_RESET, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_cmd(ihtu_pkg::KIND_CHECK, 64'd2);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'd0);
        queue_cmd(ihtu_pkg::KIND_SKIP, 64'h8000_0000_0000_0000);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_cmd(ihtu_pkg::KIND_CHECK, 64'h5555_5555_5555_5555);
        queue_cmd(ihtu_pkg::KIND_RESET, 64'd0);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'd1);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'd2);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'd3);
        queue_cmd(ihtu_pkg::KIND_MARK, 64'd1003);
        queue_cmd(ihtu_pkg::KIND_CHECK, 64'd2000);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            w = (p == 7) ? CW'($urandom_range(1, 127)) : CW'(phase_window[p]);
            repeat ($urandom_range(0, 5)) @(negedge clk);
            cfg_we <= 1'b1;
            cfg_data <= w;
            @(negedge clk);
            cfg_we <= 1'b0;
            gen_phase(phase_items[p], phase_reset[p]);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
